// File: src/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit free-list allocator: command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

   localparam int OFF_W   = 10;   // byte offset and byte count fields
   localparam int BYTES_W = 10;

   typedef logic [1:0] ffa_rdsel_type;

   // header read address sources
   localparam ffa_rdsel_type RD_HEAD = 2'd0;
   localparam ffa_rdsel_type RD_LINK = 2'd1;
   localparam ffa_rdsel_type RD_NODE = 2'd2;
   localparam ffa_rdsel_type RD_NX   = 2'd3;

   typedef struct packed {
      logic          accept;       // latch request fields
      ffa_rdsel_type rd_sel;       // header read address for the next cycle
      logic          walk_init;    // cursor to list head
      logic          walk_adv;     // cursor to next link
      logic          a_unlink;     // exact fit: unlink current block
      logic          a_split;      // shrink current block, remember tail
      logic          a_cut_wr;     // write header of the tail block
      logic          fh_empty;     // free into an empty list
      logic          cap_node;     // capture size of freed block
      logic          fh_link;      // freed block becomes new head
      logic          f_found;      // insertion point found
      logic          f_mrg_nx;     // merge with following block if adjacent
      logic          f_wr_node;    // write header of freed block
      logic          f_wr_cur;     // update predecessor header
      logic          res_fail;     // result: failure
      logic          res_free_ok;  // result: free done
      logic          rsp_load;     // move result into the output register
   } ffa_cmd_type;

   typedef struct packed {
      logic zero_req;
      logic off_bad;
      logic head_valid;
      logic node_lt_head;
      logic fit_exact;
      logic fit_split;
      logic can_adv;
      logic is_node;
      logic found;
      logic nx_in_range;
   } ffa_sts_type;

endpackage

`default_nettype wire

// File: src/ffa_ram.sv
// ----------------------------------------------------------------------------
// ffa_ram
// Generic single-write, single-read RAM with registered read data
// (read returns the old contents on a same-address write).
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer for allocate and free requests: walks the free list one header
// per cycle through the datapath and hands the result to the output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic                req_action,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   input  wire ffa_pkg::ffa_sts_type sts,
   output      ffa_pkg::ffa_cmd_type cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_A_START = 4'd1;
   localparam logic [3:0] S_A_EVAL  = 4'd2;
   localparam logic [3:0] S_A_CUT   = 4'd3;
   localparam logic [3:0] S_F_START = 4'd4;
   localparam logic [3:0] S_FH_RDN  = 4'd5;
   localparam logic [3:0] S_FH_MRG  = 4'd6;
   localparam logic [3:0] S_F_WALK  = 4'd7;
   localparam logic [3:0] S_F_RDN   = 4'd8;
   localparam logic [3:0] S_F_RDX   = 4'd9;
   localparam logic [3:0] S_F_WN    = 4'd10;
   localparam logic [3:0] S_F_WC    = 4'd11;
   localparam logic [3:0] S_RESP    = 4'd12;

   localparam logic ACT_FREE = 1'b1;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = ffa_pkg::RD_HEAD;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = (req_action == ACT_FREE) ? S_F_START : S_A_START;
            end
         end
         S_A_START: begin
            if (sts.zero_req || !sts.head_valid) begin
               cmd.res_fail = 1'b1;
               state_in     = S_RESP;
            end else begin
               cmd.rd_sel    = ffa_pkg::RD_HEAD;
               cmd.walk_init = 1'b1;
               state_in      = S_A_EVAL;
            end
         end
         S_A_EVAL: begin
            if (sts.fit_exact) begin
               cmd.a_unlink = 1'b1;
               state_in     = S_RESP;
            end else if (sts.fit_split) begin
               cmd.a_split = 1'b1;
               state_in    = S_A_CUT;
            end else if (sts.can_adv) begin
               cmd.walk_adv = 1'b1;
               cmd.rd_sel   = ffa_pkg::RD_LINK;
            end else begin
               cmd.res_fail = 1'b1;
               state_in     = S_RESP;
            end
         end
         S_A_CUT: begin
            cmd.a_cut_wr = 1'b1;
            state_in     = S_RESP;
         end
         S_F_START: begin
            if (sts.off_bad) begin
               cmd.res_fail = 1'b1;
               state_in     = S_RESP;
            end else if (!sts.head_valid) begin
               cmd.fh_empty    = 1'b1;
               cmd.res_free_ok = 1'b1;
               state_in        = S_RESP;
            end else if (sts.node_lt_head) begin
               cmd.rd_sel = ffa_pkg::RD_NODE;
               state_in   = S_FH_RDN;
            end else begin
               cmd.rd_sel    = ffa_pkg::RD_HEAD;
               cmd.walk_init = 1'b1;
               state_in      = S_F_WALK;
            end
         end
         S_FH_RDN: begin
            cmd.cap_node = 1'b1;
            cmd.rd_sel   = ffa_pkg::RD_HEAD;
            state_in     = S_FH_MRG;
         end
         S_FH_MRG: begin
            cmd.fh_link     = 1'b1;
            cmd.res_free_ok = 1'b1;
            state_in        = S_RESP;
         end
         S_F_WALK: begin
            if (sts.is_node) begin
               // block is already free
               cmd.res_fail = 1'b1;
               state_in     = S_RESP;
            end else if (sts.found) begin
               cmd.f_found = 1'b1;
               cmd.rd_sel  = ffa_pkg::RD_NODE;
               state_in    = S_F_RDN;
            end else if (sts.can_adv) begin
               cmd.walk_adv = 1'b1;
               cmd.rd_sel   = ffa_pkg::RD_LINK;
            end else begin
               cmd.res_fail = 1'b1;
               state_in     = S_RESP;
            end
         end
         S_F_RDN: begin
            cmd.cap_node = 1'b1;
            if (sts.nx_in_range) begin
               cmd.rd_sel = ffa_pkg::RD_NX;
               state_in   = S_F_RDX;
            end else begin
               state_in = S_F_WN;
            end
         end
         S_F_RDX: begin
            cmd.f_mrg_nx = 1'b1;
            state_in     = S_F_WN;
         end
         S_F_WN: begin
            cmd.f_wr_node = 1'b1;
            state_in      = S_F_WC;
         end
         S_F_WC: begin
            cmd.f_wr_cur    = 1'b1;
            cmd.res_free_ok = 1'b1;
            state_in        = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a waiting beat");

   a_valid_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.rsp_load))
      else $error("result beat raised without a load");

   a_wr_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.walk_init, cmd.walk_adv, cmd.a_unlink, cmd.a_split, cmd.a_cut_wr,
                cmd.fh_empty, cmd.fh_link, cmd.f_wr_node, cmd.f_wr_cur}))
      else $error("conflicting datapath commands");

   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_A_START || state_ff == S_F_START))
      else $error("accepted request did not start");

endmodule

`default_nettype wire

// File: src/ffa_dp.sv
// ----------------------------------------------------------------------------
// ffa_dp
// Datapath of the allocator: list head, walk cursor, size and link header
// RAMs, header arithmetic and the result / output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_dp #(
   parameter int HEAP_BYTES = 1024,
   parameter int UNIT_SHIFT = 3
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ffa_pkg::ffa_cmd_type           cmd,
   output      ffa_pkg::ffa_sts_type           sts,
   input  wire logic [ffa_pkg::BYTES_W-1:0]   req_request_bytes,
   input  wire logic [ffa_pkg::OFF_W-1:0]     req_free_offset,
   output      logic [ffa_pkg::OFF_W-1:0]     rsp_block_offset,
   output      logic                          rsp_success
);

   localparam int UNITS = HEAP_BYTES >> UNIT_SHIFT;
   localparam int IW    = $clog2(UNITS);
   localparam int SW    = IW + 1;
   localparam int LW    = IW + 1;
   localparam int OW    = ffa_pkg::OFF_W;
   localparam int CW    = ((SW > OW) ? SW : OW) + 2;
   localparam logic [CW-1:0] UNITS_C = CW'(UNITS);
   localparam logic [SW-1:0] UNITS_S = SW'(UNITS);
   localparam logic [CW-1:0] UNIT_M1 = CW'((1 << UNIT_SHIFT) - 1);
   localparam logic [OW-1:0] LOW_MASK = OW'((1 << UNIT_SHIFT) - 1);

   function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
      logic [SW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, UNITS_S}) ? UNITS_S : s[SW-1:0];
   endfunction

   function automatic logic [OW-1:0] off_of(input logic [IW-1:0] u);
      logic [31:0] t;
      t = (32'(u) + 32'd1) << UNIT_SHIFT;
      return t[OW-1:0];
   endfunction

   // header RAM ports
   logic          swe, lwe;
   logic [IW-1:0] swa, lwa, raddr;
   logic [SW-1:0] swd, size_rd_raw, size_rd;
   logic [LW-1:0] lwd, link_rd_raw, link_rd;
   logic [IW-1:0] lnk_rd;
   logic          lv_rd;

   // state
   logic [IW-1:0] head_ff, head_in;
   logic          hv_ff, hv_in;
   logic          size0_fresh_ff, size0_fresh_in;
   logic          link0_fresh_ff, link0_fresh_in;
   logic          raddr0_ff, raddr0_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [IW-1:0] prev_ff, prev_in;
   logic          prev_ok_ff, prev_ok_in;
   logic [SW-1:0] steps_ff, steps_in;
   logic [IW-1:0] node_ff, node_in;
   logic [CW-1:0] need_ff, need_in;
   logic          zero_ff, zero_in;
   logic          offbad_ff, offbad_in;
   logic [IW-1:0] cut_ff, cut_in;
   logic [SW-1:0] csz_ff, csz_in;
   logic [IW-1:0] nx_ff, nx_in;
   logic          nxv_ff, nxv_in;
   logic [SW-1:0] nsz_ff, nsz_in;
   logic [IW-1:0] nlk_ff, nlk_in;
   logic          nlv_ff, nlv_in;
   logic [OW-1:0] res_off_ff, res_off_in;
   logic          res_ok_ff, res_ok_in;
   logic [OW-1:0] rsp_off_ff, rsp_off_in;
   logic          rsp_ok_ff, rsp_ok_in;

   // request decode
   logic [CW-1:0] bytes_c, offu_c;
   logic          off_low_bad;

   // header arithmetic
   logic [CW-1:0] sz_c, cut_c;
   logic [SW-1:0] rest;
   logic          size_gt;
   logic          head_adj, nx_adj, cur_adj;

   // entry 0 keeps its reset header until first written
   assign size_rd = (size0_fresh_ff && raddr0_ff) ? UNITS_S : size_rd_raw;
   assign link_rd = (link0_fresh_ff && raddr0_ff) ? '0 : link_rd_raw;
   assign lv_rd   = link_rd[LW-1];
   assign lnk_rd  = link_rd[IW-1:0];

   assign bytes_c     = CW'(req_request_bytes);
   assign offu_c      = CW'(req_free_offset) >> UNIT_SHIFT;
   assign off_low_bad = (req_free_offset & LOW_MASK) != '0;

   assign sz_c     = CW'(size_rd);
   assign size_gt  = sz_c > need_ff;
   assign rest     = size_rd - SW'(need_ff);
   assign cut_c    = CW'(cur_ff) + CW'(rest);
   assign head_adj = (CW'(node_ff) + CW'(nsz_ff)) == CW'(head_ff);
   assign nx_adj   = (CW'(node_ff) + CW'(nsz_ff)) == CW'(nx_ff);
   assign cur_adj  = (CW'(cur_ff) + CW'(csz_ff)) == CW'(node_ff);

   always_comb begin
      sts.zero_req     = zero_ff;
      sts.off_bad      = offbad_ff;
      sts.head_valid   = hv_ff;
      sts.node_lt_head = node_ff < head_ff;
      sts.fit_exact    = sz_c == need_ff;
      sts.fit_split    = size_gt && (cut_c < UNITS_C);
      sts.can_adv      = lv_rd && ((CW'(steps_ff) + CW'(1)) < UNITS_C)
                         && (CW'(lnk_rd) < UNITS_C);
      sts.is_node      = cur_ff == node_ff;
      sts.found        = (cur_ff < node_ff) && (!lv_rd || (lnk_rd > node_ff));
      sts.nx_in_range  = nxv_ff && (CW'(nx_ff) < UNITS_C);
   end

   always_comb begin
      case (cmd.rd_sel)
         ffa_pkg::RD_HEAD: raddr = head_ff;
         ffa_pkg::RD_LINK: raddr = lnk_rd;
         ffa_pkg::RD_NODE: raddr = node_ff;
         ffa_pkg::RD_NX:   raddr = nx_ff;
         default:          raddr = head_ff;
      endcase
   end

   // header write ports
   always_comb begin
      swe = 1'b0;
      swa = cur_ff;
      swd = rest;
      if (cmd.a_split) begin
         swe = 1'b1;
      end else if (cmd.a_cut_wr) begin
         swe = 1'b1;
         swa = cut_ff;
         swd = SW'(need_ff);
      end else if (cmd.fh_link && head_adj) begin
         swe = 1'b1;
         swa = node_ff;
         swd = sat_add(nsz_ff, size_rd);
      end else if (cmd.f_wr_node) begin
         swe = 1'b1;
         swa = node_ff;
         swd = nsz_ff;
      end else if (cmd.f_wr_cur && cur_adj) begin
         swe = 1'b1;
         swd = sat_add(csz_ff, nsz_ff);
      end

      lwe = 1'b0;
      lwa = node_ff;
      lwd = link_rd;
      if (cmd.a_unlink && prev_ok_ff) begin
         lwe = 1'b1;
         lwa = prev_ff;
      end else if (cmd.fh_empty) begin
         lwe = 1'b1;
         lwd = {hv_ff, head_ff};
      end else if (cmd.fh_link) begin
         lwe = 1'b1;
         lwd = head_adj ? link_rd : {1'b1, head_ff};
      end else if (cmd.f_wr_node) begin
         lwe = 1'b1;
         lwd = {nlv_ff, nlk_ff};
      end else if (cmd.f_wr_cur) begin
         lwe = 1'b1;
         lwa = cur_ff;
         lwd = cur_adj ? {nlv_ff, nlk_ff} : {1'b1, node_ff};
      end
   end

   always_comb begin
      head_in        = head_ff;
      hv_in          = hv_ff;
      size0_fresh_in = size0_fresh_ff & ~(swe && (swa == '0));
      link0_fresh_in = link0_fresh_ff & ~(lwe && (lwa == '0));
      raddr0_in      = raddr == '0;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      prev_ok_in     = prev_ok_ff;
      steps_in       = steps_ff;
      node_in        = node_ff;
      need_in        = need_ff;
      zero_in        = zero_ff;
      offbad_in      = offbad_ff;
      cut_in         = cut_ff;
      csz_in         = csz_ff;
      nx_in          = nx_ff;
      nxv_in         = nxv_ff;
      nsz_in         = nsz_ff;
      nlk_in         = nlk_ff;
      nlv_in         = nlv_ff;
      res_off_in     = res_off_ff;
      res_ok_in      = res_ok_ff;
      rsp_off_in     = rsp_off_ff;
      rsp_ok_in      = rsp_ok_ff;

      if (cmd.accept) begin
         need_in   = ((bytes_c + UNIT_M1) >> UNIT_SHIFT) + CW'(1);
         zero_in   = req_request_bytes == '0;
         offbad_in = off_low_bad || (offu_c == '0) || (offu_c > UNITS_C);
         node_in   = IW'(offu_c - CW'(1));
      end
      if (cmd.walk_init) begin
         cur_in     = head_ff;
         steps_in   = '0;
         prev_ok_in = 1'b0;
      end
      if (cmd.walk_adv) begin
         prev_in    = cur_ff;
         prev_ok_in = 1'b1;
         cur_in     = lnk_rd;
         steps_in   = steps_ff + SW'(1);
      end
      if (cmd.a_unlink) begin
         if (!prev_ok_ff) begin
            head_in = lnk_rd;
            hv_in   = lv_rd;
         end
         res_off_in = off_of(cur_ff);
         res_ok_in  = 1'b1;
      end
      if (cmd.a_split) begin
         cut_in     = IW'(cut_c);
         res_off_in = off_of(IW'(cut_c));
         res_ok_in  = 1'b1;
      end
      if (cmd.fh_empty || cmd.fh_link) begin
         head_in = node_ff;
         hv_in   = 1'b1;
      end
      if (cmd.cap_node) begin
         nsz_in = size_rd;
         nlk_in = nx_ff;
         nlv_in = nxv_ff;
      end
      if (cmd.f_found) begin
         nx_in  = lnk_rd;
         nxv_in = lv_rd;
         csz_in = size_rd;
      end
      if (cmd.f_mrg_nx && nx_adj) begin
         nsz_in = sat_add(nsz_ff, size_rd);
         nlk_in = lnk_rd;
         nlv_in = lv_rd;
      end
      if (cmd.res_fail) begin
         res_off_in = '0;
         res_ok_in  = 1'b0;
      end
      if (cmd.res_free_ok) begin
         res_off_in = '0;
         res_ok_in  = 1'b1;
      end
      if (cmd.rsp_load) begin
         rsp_off_in = res_off_ff;
         rsp_ok_in  = res_ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff        <= '0;
         hv_ff          <= 1'b1;
         size0_fresh_ff <= 1'b1;
         link0_fresh_ff <= 1'b1;
      end else begin
         head_ff        <= head_in;
         hv_ff          <= hv_in;
         size0_fresh_ff <= size0_fresh_in;
         link0_fresh_ff <= link0_fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      raddr0_ff  <= raddr0_in;
      cur_ff     <= cur_in;
      prev_ff    <= prev_in;
      prev_ok_ff <= prev_ok_in;
      steps_ff   <= steps_in;
      node_ff    <= node_in;
      need_ff    <= need_in;
      zero_ff    <= zero_in;
      offbad_ff  <= offbad_in;
      cut_ff     <= cut_in;
      csz_ff     <= csz_in;
      nx_ff      <= nx_in;
      nxv_ff     <= nxv_in;
      nsz_ff     <= nsz_in;
      nlk_ff     <= nlk_in;
      nlv_ff     <= nlv_in;
      res_off_ff <= res_off_in;
      res_ok_ff  <= res_ok_in;
      rsp_off_ff <= rsp_off_in;
      rsp_ok_ff  <= rsp_ok_in;
   end

   assign rsp_block_offset = rsp_off_ff;
   assign rsp_success      = rsp_ok_ff;

   ffa_ram #(
      .WIDTH (SW),
      .DEPTH (UNITS)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (swe),
      .wr_addr (swa),
      .wr_data (swd),
      .rd_addr (raddr),
      .rd_data (size_rd_raw)
   );

   ffa_ram #(
      .WIDTH (LW),
      .DEPTH (UNITS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (lwe),
      .wr_addr (lwa),
      .wr_data (lwd),
      .rd_addr (raddr),
      .rd_data (link_rd_raw)
   );

   a_head_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(hv_ff) |-> $past(cmd.a_unlink))
      else $error("list emptied outside an exact-fit unlink");

   a_pred_order: assert property (@(posedge clock) disable iff (reset)
      cmd.f_wr_cur |-> (cur_ff < node_ff))
      else $error("predecessor not below freed block");

endmodule

`default_nettype wire

// File: src/first_fit_free_list_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator
// First-fit heap allocator with an address-ordered free list and coalescing
// of freed blocks with both neighbors.
// ----------------------------------------------------------------------------
// Sequence: allocate checks the request, walks the list and writes the tail
//   header on a split; free walks to the insertion point, then merges.
// Throughput: one request in flight; the walk reads one header per cycle
//   from the size/link RAMs, so the list length sets the rate.
// Reset: synchronous; heap comes up as one free block at unit 0, ready at
//   once (no RAM clearing pass).
`default_nettype none

module first_fit_free_list_allocator #(
   parameter int HEAP_BYTES = 1024,
   parameter int UNIT_SHIFT = 3
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire logic                        req_action,
   input  wire logic [ffa_pkg::BYTES_W-1:0] req_request_bytes,
   input  wire logic [ffa_pkg::OFF_W-1:0]   req_free_offset,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      logic [ffa_pkg::OFF_W-1:0]   rsp_block_offset,
   output      logic                        rsp_success
);

   ffa_pkg::ffa_cmd_type cmd;
   ffa_pkg::ffa_sts_type sts;

   ffa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ffa_dp #(
      .HEAP_BYTES (HEAP_BYTES),
      .UNIT_SHIFT (UNIT_SHIFT)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_request_bytes (req_request_bytes),
      .req_free_offset   (req_free_offset),
      .rsp_block_offset  (rsp_block_offset),
      .rsp_success       (rsp_success)
   );

endmodule

`default_nettype wire

// File: bench/ffa_bench_pkg.sv
// ----------------------------------------------------------------------------
// ffa_bench_pkg
// Request codes shared by the allocator bench and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_bench_pkg;

   typedef enum logic {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } ffa_action_e;

endpackage

`default_nettype wire

// File: bench/ffa_heap_checker.sv
// ----------------------------------------------------------------------------
// ffa_heap_checker
// Watches both channels of the allocator and keeps its own copy of the free
// list. Each request beat is applied to that copy, and the grant it yields is
// queued. Each response beat is compared with the oldest queued grant.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_heap_checker #(
   parameter int HEAP_BYTES = 1024,
   parameter int UNIT_SHIFT = 3
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic                        req_ready,
   input  wire logic                        req_action,
   input  wire logic [ffa_pkg::BYTES_W-1:0] req_request_bytes,
   input  wire logic [ffa_pkg::OFF_W-1:0]   req_free_offset,
   input  wire logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   input  wire logic [ffa_pkg::OFF_W-1:0]   rsp_block_offset,
   input  wire logic                        rsp_success,
   output int                               mismatches,
   output int                               pending
);

   import ffa_pkg::*;
   import ffa_bench_pkg::*;

   localparam int UNITS      = HEAP_BYTES >> UNIT_SHIFT;
   localparam int UNIT_BYTES = 1 << UNIT_SHIFT;

   typedef struct packed {
      logic [OFF_W-1:0] offset;
      logic             ok;
   } grant_t;

   // free list copy: size and link per header unit
   logic [7:0] size_mem [UNITS];
   logic [7:0] link_mem [UNITS];
   logic       link_ok  [UNITS];
   int         head;
   logic       head_ok;

   grant_t     pending_grants[$];

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   function automatic void heap_reset();
      for (int i = 0; i < UNITS; i++) begin
         size_mem[i] = '0;
         link_mem[i] = '0;
         link_ok[i]  = 1'b0;
      end
      size_mem[0] = UNITS;
      head        = 0;
      head_ok     = 1'b1;
   endfunction

   function automatic int sat_units(input int a, input int b);
      return (a + b > UNITS) ? UNITS : a + b;
   endfunction

   // first fit: exact fit unlinks, larger block gives up its tail
   function automatic void carve_block(input int bytes, output logic [OFF_W-1:0] off,
                                       output logic ok);
      int   need;
      int   cur;
      int   prev;
      int   sz;
      int   rest;
      int   cut;
      logic cur_ok;
      logic prev_ok;
      off = '0;
      ok  = 1'b0;
      if (bytes == 0)
         return;
      need    = ((bytes + UNIT_BYTES - 1) >> UNIT_SHIFT) + 1;
      cur     = head;
      cur_ok  = head_ok;
      prev    = 0;
      prev_ok = 1'b0;
      for (int steps = 0; cur_ok && steps < UNITS && cur < UNITS; steps++) begin
         sz = size_mem[cur];
         if (sz == need) begin
            if (prev_ok) begin
               link_mem[prev] = link_mem[cur];
               link_ok[prev]  = link_ok[cur];
            end else begin
               head    = link_mem[cur];
               head_ok = link_ok[cur];
            end
            off = (cur + 1) << UNIT_SHIFT;
            ok  = 1'b1;
            return;
         end
         if (sz > need) begin
            rest = sz - need;
            cut  = cur + rest;
            if (cut < UNITS) begin
               size_mem[cur] = rest;
               size_mem[cut] = need;
               off = (cut + 1) << UNIT_SHIFT;
               ok  = 1'b1;
               return;
            end
         end
         prev    = cur;
         prev_ok = 1'b1;
         cur_ok  = link_ok[cur];
         cur     = link_mem[cur];
      end
   endfunction

   // address-ordered insert with merge into both neighbors
   function automatic void return_block(input int offv, output logic ok);
      int   node;
      int   cur;
      int   nx;
      logic found;
      ok    = 1'b0;
      found = 1'b0;
      if ((offv & (UNIT_BYTES - 1)) != 0 || (offv >> UNIT_SHIFT) == 0)
         return;
      node = (offv >> UNIT_SHIFT) - 1;
      if (node >= UNITS)
         return;
      if (!head_ok || node < head) begin
         if (head_ok && node + int'(size_mem[node]) == head) begin
            size_mem[node] = sat_units(size_mem[node], size_mem[head]);
            link_mem[node] = link_mem[head];
            link_ok[node]  = link_ok[head];
         end else begin
            link_mem[node] = head;
            link_ok[node]  = head_ok;
         end
         head    = node;
         head_ok = 1'b1;
         ok      = 1'b1;
         return;
      end
      cur = head;
      for (int steps = 0; steps < UNITS && cur < UNITS; steps++) begin
         if (cur == node)
            return;
         if (cur < node && (!link_ok[cur] || int'(link_mem[cur]) > node)) begin
            found = 1'b1;
            break;
         end
         if (!link_ok[cur])
            break;
         cur = link_mem[cur];
      end
      if (!found)
         return;
      nx = link_mem[cur];
      if (link_ok[cur] && nx < UNITS && node + int'(size_mem[node]) == nx) begin
         size_mem[node] = sat_units(size_mem[node], size_mem[nx]);
         link_mem[node] = link_mem[nx];
         link_ok[node]  = link_ok[nx];
      end else begin
         link_mem[node] = nx;
         link_ok[node]  = link_ok[cur];
      end
      if (cur + int'(size_mem[cur]) == node) begin
         size_mem[cur] = sat_units(size_mem[cur], size_mem[node]);
         link_mem[cur] = link_mem[node];
         link_ok[cur]  = link_ok[node];
      end else begin
         link_mem[cur] = node;
         link_ok[cur]  = 1'b1;
      end
      ok = 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      grant_t           want;
      logic [OFF_W-1:0] off;
      logic             ok;
      if (reset) begin
         heap_reset();
         pending_grants.delete();
      end else begin
         // response first: a beat at the same edge as its request is an error
         if (rsp_valid && rsp_ready) begin
            if (pending_grants.size() == 0) begin
               mismatches++;
               $display("%0t: response beat with nothing expected, got offset %0d success %0b",
                        $time, rsp_block_offset, rsp_success);
            end else begin
               want = pending_grants.pop_front();
               if (rsp_block_offset !== want.offset) begin
                  mismatches++;
                  $display("%0t: block_offset expected %0d got %0d",
                           $time, want.offset, rsp_block_offset);
               end
               if (rsp_success !== want.ok) begin
                  mismatches++;
                  $display("%0t: success expected %0b got %0b", $time, want.ok, rsp_success);
               end
            end
         end
         if (req_valid && req_ready) begin
            off = '0;
            if (req_action == ACT_ALLOC)
               carve_block(req_request_bytes, off, ok);
            else
               return_block(req_free_offset, ok);
            pending_grants.push_back('{offset: off, ok: ok});
         end
      end
      pending = pending_grants.size();
   end

endmodule

`default_nettype wire

// File: bench/tb_first_fit_free_list_allocator.sv
// ----------------------------------------------------------------------------
// tb_first_fit_free_list_allocator
// Drives allocate and free beats into the allocator with random gaps and
// response stalls. Frees only name blocks it was granted, bad offsets, or the
// head of a whole heap. The checker beside the block predicts every response.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_first_fit_free_list_allocator;

   import ffa_pkg::*;
   import ffa_bench_pkg::*;

   localparam int HEAP_BYTES  = 1024;
   localparam int UNIT_SHIFT  = 3;
   localparam int UNIT_BYTES  = 1 << UNIT_SHIFT;
   localparam int ITEM_TARGET = 1700;
   localparam int CALM_AFTER  = 1450;
   localparam int TAIL_CYCLES = 150;

   logic               clock             = 1'b0;
   logic               reset             = 1'b1;
   logic               req_valid         = 1'b0;
   logic               req_action        = ACT_ALLOC;
   logic [BYTES_W-1:0] req_request_bytes = '0;
   logic [OFF_W-1:0]   req_free_offset   = '0;
   logic               rsp_ready         = 1'b0;
   logic               req_ready;
   logic               rsp_valid;
   logic [OFF_W-1:0]   rsp_block_offset;
   logic               rsp_success;

   int                 mismatches;
   int                 pending;

   int                 items_sent = 0;
   int                 beats_in   = 0;
   int                 beats_out  = 0;
   logic               idle_on    = 1'b1;
   ffa_action_e        action_log[$];
   int                 live_blocks[$];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   first_fit_free_list_allocator #(
      .HEAP_BYTES(HEAP_BYTES),
      .UNIT_SHIFT(UNIT_SHIFT)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_request_bytes(req_request_bytes),
      .req_free_offset  (req_free_offset),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_block_offset (rsp_block_offset),
      .rsp_success      (rsp_success)
   );

   ffa_heap_checker #(
      .HEAP_BYTES(HEAP_BYTES),
      .UNIT_SHIFT(UNIT_SHIFT)
   ) i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_request_bytes(req_request_bytes),
      .req_free_offset  (req_free_offset),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_block_offset (rsp_block_offset),
      .rsp_success      (rsp_success),
      .mismatches       (mismatches),
      .pending          (pending)
   );

   // Levels only move at rising edges, so a handshake seen high here is the
   // beat that lands at the next rising edge. Keeps the granted-offset list
   // settled before the stimulus reads it.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            beats_in++;
            action_log.push_back(ffa_action_e'(req_action));
         end
         if (rsp_valid && rsp_ready) begin
            beats_out++;
            if (action_log.size() != 0) begin
               if (action_log.pop_front() == ACT_ALLOC && rsp_success)
                  live_blocks.push_back(rsp_block_offset);
            end
         end
      end
   end

   // response side stalls in bursts
   initial begin : rsp_side
      int n;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 13);
            rsp_ready <= 1'b0;
            repeat (n - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // called at a rising edge; returns at the edge where the beat is taken
   task automatic send_beat(input ffa_action_e act, input int bytes, input int offv);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= act;
      req_request_bytes <= bytes;
      req_free_offset   <= offv;
      items_sent++;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic alloc_beat(input int bytes);
      send_beat(ACT_ALLOC, bytes, $urandom_range(0, HEAP_BYTES - 1));
   endtask

   task automatic free_raw(input int offv);
      send_beat(ACT_FREE, $urandom_range(0, HEAP_BYTES - 1), offv);
   endtask

   task automatic free_live(input int idx);
      int offv;
      offv = live_blocks[idx];
      live_blocks.delete(idx);
      free_raw(offv);
   endtask

   // sender holds off until every response is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (beats_in != beats_out) @(posedge clock);
   endtask

   function automatic int pick_bytes();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return $urandom_range(1, 48);
      if (r < 85)
         return $urandom_range(49, 200);
      return $urandom_range(0, HEAP_BYTES - 1);
   endfunction

   initial begin : stimulus
      int cnt;
      int r;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // whole heap: first unit is already listed; bad offsets; zero and
      // oversized requests; exact fit on the head empties the list
      free_raw(UNIT_BYTES);
      free_raw(0);
      free_raw(HEAP_BYTES - 1);
      free_raw(UNIT_BYTES / 2);
      alloc_beat(0);
      alloc_beat(HEAP_BYTES - 1);
      alloc_beat(HEAP_BYTES - UNIT_BYTES);
      alloc_beat(1);
      drain();
      // free into an empty list, then the same block again while listed
      free_live(0);
      free_raw(UNIT_BYTES);
      alloc_beat(1);
      alloc_beat(UNIT_BYTES);
      drain();
      // head block of 124 units taken whole, head moves to the upper block
      free_live(0);
      alloc_beat(HEAP_BYTES - 5 * UNIT_BYTES);
      drain();
      // below the head, then the gap block merges both ways
      free_live(1);
      free_live(0);
      drain();

      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= CALM_AFTER)
            idle_on = 1'b0;
         case ($urandom_range(0, 9))
            0, 1: begin
               // fill with small blocks, punch every other one out, then walk
               repeat ($urandom_range(30, 70)) alloc_beat($urandom_range(1, 16));
               drain();
               cnt = live_blocks.size();
               for (int i = 0; i < cnt / 2; i++)
                  free_live(i);
               repeat (4) alloc_beat($urandom_range(17, 300));
            end
            2: begin
               drain();
               while (live_blocks.size() != 0)
                  free_live($urandom_range(0, live_blocks.size() - 1));
               drain();
               // heap is one block again, so its head is a listed node
               free_raw(UNIT_BYTES);
            end
            default: begin
               repeat (30) begin
                  r = $urandom_range(0, 99);
                  if (r < 50 || (live_blocks.size() == 0 && r < 90))
                     alloc_beat(pick_bytes());
                  else if (r < 90)
                     free_live($urandom_range(0, live_blocks.size() - 1));
                  else if (r < 93)
                     free_raw(0);
                  else if (r < 97)
                     free_raw(($urandom_range(0, HEAP_BYTES / UNIT_BYTES - 1) << UNIT_SHIFT)
                              | $urandom_range(1, UNIT_BYTES - 1));
                  else
                     alloc_beat(0);
               end
            end
         endcase
      end

      idle_on = 1'b0;
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending != 0)
         $display("%0t: %0d responses never arrived", $time, pending);
      if (mismatches == 0 && pending == 0) begin
         $display("tb_first_fit_free_list_allocator passed");
      end else begin
         $display("tb_first_fit_free_list_allocator failed");
      end
      $finish;
   end

   initial begin : watchdog
      #9_600_000;
      $display("tb_first_fit_free_list_allocator failed");
      $finish;
   end

endmodule

`default_nettype wire
